[rtl/core/afra_pkg.sv]
`default_nettype none

package afra_pkg;

   localparam int DEF_MAX_BORROWS  = 16;
   localparam int DEF_OFFSET_WIDTH = 32;
   localparam logic [31:0] CAP_RESET = 32'd65536;

   // Operation codes.
   localparam logic FUNC_BORROW = 1'b0;
   localparam logic FUNC_RETURN = 1'b1;

   // Result status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
   localparam logic [2:0] ST_ZERO_ALIGN = 3'd2;
   localparam logic [2:0] ST_NO_SPACE   = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;
   localparam logic [2:0] ST_BAD_RETURN = 3'd5;

   typedef struct packed {
      logic        func;
      logic [31:0] request_size;
      logic [31:0] request_alignment;
      logic [31:0] return_id;
      logic [31:0] return_offset;
      logic [31:0] return_size;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] granted_id;
      logic [31:0] granted_offset;
      logic [31:0] free_total;
      logic [4:0]  borrow_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       cfg_take;
      logic       init;
      logic       set_st;
      logic [2:0] st_code;
      logic       tag_rd;
      logic       j_inc;
      logic       slot_take;
      logic       hit_take;
      logic       free_rd;
      logic       div_go;
      logic       align_latch;
      logic       i_inc;
      logic       rb_start;
      logic       rb_rd;
      logic       rb_first;
      logic       rb_second;
      logic       rb_tail;
      logic       rb_flush;
      logic       commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_ret;
      logic size0;
      logic align0;
      logic id0;
      logic tag_free;
      logic tag_match;
      logic j_last;
      logic i_lt;
      logic div_done;
      logic fits;
      logic k_lt;
      logic need_second;
   } sts_type;

endpackage

`default_nettype wire

[rtl/core/afra_div.sv]
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle.
module afra_div #(
   parameter int OFFSET_WIDTH = afra_pkg::DEF_OFFSET_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    go,
   input  wire logic [OFFSET_WIDTH-1:0] dividend,
   input  wire logic [31:0]             divisor,
   output logic                         done,
   output logic [31:0]                  rem
);

   localparam int NW = $clog2(OFFSET_WIDTH + 1);

   logic                    run_ff, run_in;
   logic [NW-1:0]           cnt_ff, cnt_in;
   logic [31:0]             rem_ff, rem_in;
   logic [OFFSET_WIDTH-1:0] dvd_ff, dvd_in;
   logic [31:0]             dsr_ff, dsr_in;
   logic [32:0]             trial;

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      trial  = {rem_ff, dvd_ff[OFFSET_WIDTH-1]};
      if (go) begin
         run_in = 1'b1;
         cnt_in = NW'(OFFSET_WIDTH);
         rem_in = 32'd0;
         dvd_in = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 32'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[31:0];
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done = !run_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

[rtl/core/afra_ctrl.sv]
`default_nettype none

// Sequencer for the allocator: checks, tag scan, first-fit scan and list rebuild.
module afra_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              csr_valid,
   input  wire afra_pkg::sts_type sts,
   output logic                   busy,
   output logic                   csr_ready,
   output logic                   rsp_valid,
   output afra_pkg::cmd_type      cmd
);

   localparam logic [4:0] S_INIT      = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_CHECK     = 5'd2;
   localparam logic [4:0] S_TAG_RD    = 5'd3;
   localparam logic [4:0] S_TAG_CHK   = 5'd4;
   localparam logic [4:0] S_FREE_RD   = 5'd5;
   localparam logic [4:0] S_DIV_GO    = 5'd6;
   localparam logic [4:0] S_DIV_WAIT  = 5'd7;
   localparam logic [4:0] S_ALIGN     = 5'd8;
   localparam logic [4:0] S_FIT       = 5'd9;
   localparam logic [4:0] S_RB_RD     = 5'd10;
   localparam logic [4:0] S_RB_FIRST  = 5'd11;
   localparam logic [4:0] S_RB_SECOND = 5'd12;
   localparam logic [4:0] S_RB_TAIL   = 5'd13;
   localparam logic [4:0] S_RB_FLUSH  = 5'd14;
   localparam logic [4:0] S_COMMIT    = 5'd15;
   localparam logic [4:0] S_FIN       = 5'd16;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (csr_valid && !start) begin
               cmd.cfg_take = 1'b1;
               state_in     = S_INIT;
            end else if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (!sts.is_ret && sts.size0) begin
               cmd.set_st  = 1'b1;
               cmd.st_code = afra_pkg::ST_ZERO_SIZE;
               state_in    = S_FIN;
            end else if (!sts.is_ret && sts.align0) begin
               cmd.set_st  = 1'b1;
               cmd.st_code = afra_pkg::ST_ZERO_ALIGN;
               state_in    = S_FIN;
            end else if (sts.is_ret && sts.id0) begin
               cmd.set_st  = 1'b1;
               cmd.st_code = afra_pkg::ST_BAD_RETURN;
               state_in    = S_FIN;
            end else begin
               state_in = S_TAG_RD;
            end
         end
         S_TAG_RD: begin
            if (sts.is_ret) begin
               cmd.tag_rd = 1'b1;
               state_in   = S_TAG_CHK;
            end else if (sts.tag_free) begin
               cmd.slot_take = 1'b1;
               state_in      = S_FREE_RD;
            end else if (sts.j_last) begin
               cmd.set_st  = 1'b1;
               cmd.st_code = afra_pkg::ST_TABLE_FULL;
               state_in    = S_FIN;
            end else begin
               cmd.j_inc = 1'b1;
            end
         end
         S_TAG_CHK: begin
            if (sts.tag_match) begin
               cmd.hit_take = 1'b1;
               cmd.rb_start = 1'b1;
               state_in     = S_RB_RD;
            end else if (sts.j_last) begin
               cmd.set_st  = 1'b1;
               cmd.st_code = afra_pkg::ST_BAD_RETURN;
               state_in    = S_FIN;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = S_TAG_RD;
            end
         end
         S_FREE_RD: begin
            if (sts.i_lt) begin
               cmd.free_rd = 1'b1;
               state_in    = S_DIV_GO;
            end else begin
               cmd.set_st  = 1'b1;
               cmd.st_code = afra_pkg::ST_NO_SPACE;
               state_in    = S_FIN;
            end
         end
         S_DIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (sts.div_done) begin
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            cmd.align_latch = 1'b1;
            state_in        = S_FIT;
         end
         S_FIT: begin
            if (sts.fits) begin
               cmd.rb_start = 1'b1;
               state_in     = S_RB_RD;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_FREE_RD;
            end
         end
         S_RB_RD: begin
            if (sts.k_lt) begin
               cmd.rb_rd = 1'b1;
               state_in  = S_RB_FIRST;
            end else begin
               state_in = S_RB_TAIL;
            end
         end
         S_RB_FIRST: begin
            cmd.rb_first = 1'b1;
            state_in     = sts.need_second ? S_RB_SECOND : S_RB_RD;
         end
         S_RB_SECOND: begin
            cmd.rb_second = 1'b1;
            state_in      = S_RB_RD;
         end
         S_RB_TAIL: begin
            cmd.rb_tail = 1'b1;
            state_in    = S_RB_FLUSH;
         end
         S_RB_FLUSH: begin
            cmd.rb_flush = 1'b1;
            state_in     = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit  = 1'b1;
            cmd.set_st  = 1'b1;
            cmd.st_code = afra_pkg::ST_OK;
            state_in    = S_FIN;
         end
         S_FIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_valid = (state_ff == S_FIN);

endmodule

`default_nettype wire

[rtl/core/afra_dp.sv]
`default_nettype none

// Datapath: free-range list (two banks), borrow table, alignment and merge arithmetic.
module afra_dp #(
   parameter int MAX_BORROWS  = afra_pkg::DEF_MAX_BORROWS,
   parameter int OFFSET_WIDTH = afra_pkg::DEF_OFFSET_WIDTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire afra_pkg::cmd_type cmd,
   input  wire afra_pkg::req_type req_data,
   input  wire logic [31:0]       csr_data,
   output afra_pkg::sts_type      sts,
   output afra_pkg::rsp_type      rsp_data
);

   localparam int OW = OFFSET_WIDTH;
   localparam int MB = MAX_BORROWS;
   localparam int FS = MB + 2;
   localparam int IW = $clog2(FS);
   localparam int CW = $clog2(FS + 1);
   localparam int JW = (MB > 1) ? $clog2(MB) : 1;
   localparam int BW = $clog2(MB + 1);
   localparam int XW = ((OW > 32) ? OW : 32) + 1;
   localparam int EW = 32 + OW + 32;
   localparam logic [63:0] OMAX = (64'd1 << OW) - 64'd1;

   // Stores.
   logic [2*OW-1:0] free_mem [0:1][0:FS-1];
   logic [EW-1:0]   ext_mem  [0:MB-1];
   logic [2*OW-1:0] rd_q;
   logic [EW-1:0]   ext_q;

   // Registers.
   afra_pkg::req_type req_ff, req_in;
   logic [31:0]   cap_ff, cap_in;
   logic          bank_ff, bank_in;
   logic [CW-1:0] fcnt_ff, fcnt_in, i_ff, i_in, k_ff, k_in, m_ff, m_in;
   logic [JW-1:0] j_ff, j_in, sel_ff, sel_in;
   logic [OW-1:0] cur_off_ff, cur_off_in, cur_sz_ff, cur_sz_in, a_ff, a_in;
   logic [OW-1:0] acc_ff, acc_in, total_ff, total_in;
   logic [OW-1:0] pend_off_ff, pend_off_in, pend_sz_ff, pend_sz_in;
   logic          pend_v_ff, pend_v_in, placed_ff, placed_in;
   logic [MB-1:0] valid_ff, valid_in;
   logic [BW-1:0] bcnt_ff, bcnt_in;
   logic [31:0]   nid_ff, nid_in, gid_ff, gid_in, goff_ff, goff_in;
   logic [2:0]    st_ff, st_in;

   // Working signals.
   logic [OW-1:0] old_off, old_sz, capc, a_calc, e_off, e_sz;
   logic [63:0]   cap64, a64, tot64, bcnt64;
   logic [XW-1:0] v_x, inc_x, room_x, pad_x, take_end_x, end_x;
   logic [XW-1:0] pend_end_x, e_end_x, emax_x;
   logic [31:0]   rem, ext_id, ext_sz;
   logic [OW-1:0] ext_off;
   logic          div_done, is_ret, ins_before, tail_ok, at_hit, need_second;
   logic          mg, do_proc, fresh_sel, fits;
   logic          wr_en, rd_en;
   logic [IW-1:0] rd_idx;
   logic [2*OW-1:0] wr_d;

   assign old_off = rd_q[2*OW-1:OW];
   assign old_sz  = rd_q[OW-1:0];
   assign ext_id  = ext_q[EW-1:OW+32];
   assign ext_off = ext_q[OW+31:32];
   assign ext_sz  = ext_q[31:0];
   assign is_ret  = (req_ff.func == afra_pkg::FUNC_RETURN);

   assign cap64 = 64'(cap_ff);
   assign capc  = (cap64 > OMAX) ? OMAX[OW-1:0] : cap64[OW-1:0];

   afra_div #(.OFFSET_WIDTH(OW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (old_off),
      .divisor  (req_ff.request_alignment),
      .done     (div_done),
      .rem      (rem)
   );

   // Round the range start up to the alignment, saturating at the top offset.
   always_comb begin
      v_x    = XW'(cur_off_ff);
      inc_x  = XW'(req_ff.request_alignment) - XW'(rem);
      room_x = XW'(OMAX[OW-1:0]) - v_x;
      if (rem == 32'd0) begin
         a_calc = cur_off_ff;
      end else if (inc_x > room_x) begin
         a_calc = OMAX[OW-1:0];
      end else begin
         a_calc = OW'(v_x + inc_x);
      end
   end

   // Fit test and the pieces left over around the granted block.
   assign pad_x      = XW'(a_ff) - XW'(cur_off_ff);
   assign fits       = (pad_x <= XW'(cur_sz_ff)) &&
                       (XW'(req_ff.request_size) <= XW'(cur_sz_ff) - pad_x);
   assign take_end_x = XW'(a_ff) + XW'(req_ff.request_size);
   assign end_x      = XW'(cur_off_ff) + XW'(cur_sz_ff);
   assign tail_ok    = take_end_x < end_x;
   assign at_hit     = (k_ff == i_ff);

   // On a return the freed range goes in before the first range that starts above it.
   assign ins_before  = !placed_ff && (old_off > cur_off_ff);
   assign need_second = is_ret ? ins_before : (at_hit && tail_ok);

   assign fresh_sel = (cmd.rb_first && ins_before) || cmd.rb_tail;
   assign e_off     = fresh_sel ? cur_off_ff : old_off;
   assign e_sz      = fresh_sel ? cur_sz_ff : old_sz;
   assign do_proc   = is_ret && (cmd.rb_first || cmd.rb_second ||
                                 (cmd.rb_tail && !placed_ff));

   // Merge the element into the pending range when they touch or overlap.
   assign pend_end_x = XW'(pend_off_ff) + XW'(pend_sz_ff);
   assign e_end_x    = XW'(e_off) + XW'(e_sz);
   assign emax_x     = (pend_end_x > e_end_x) ? pend_end_x : e_end_x;
   assign mg         = pend_v_ff && (pend_end_x >= XW'(e_off));

   // Free-list write port.
   always_comb begin
      wr_en = 1'b0;
      wr_d  = rd_q;
      if (cmd.init) begin
         wr_en = 1'b1;
         wr_d  = {{OW{1'b0}}, capc};
      end else if (do_proc) begin
         wr_en = !mg && pend_v_ff;
         wr_d  = {pend_off_ff, pend_sz_ff};
      end else if (is_ret && cmd.rb_flush) begin
         wr_en = pend_v_ff;
         wr_d  = {pend_off_ff, pend_sz_ff};
      end else if (!is_ret && cmd.rb_first) begin
         if (at_hit) begin
            wr_en = (pad_x != '0);
            wr_d  = {cur_off_ff, OW'(pad_x)};
         end else begin
            wr_en = 1'b1;
            wr_d  = rd_q;
         end
      end else if (!is_ret && cmd.rb_second) begin
         wr_en = 1'b1;
         wr_d  = {OW'(take_end_x), OW'(end_x - take_end_x)};
      end
   end

   assign rd_en  = cmd.free_rd || cmd.rb_rd;
   assign rd_idx = cmd.free_rd ? i_ff[IW-1:0] : k_ff[IW-1:0];

   assign a64 = 64'(a_ff);

   always_comb begin
      req_in      = req_ff;
      cap_in      = cap_ff;
      bank_in     = bank_ff;
      fcnt_in     = fcnt_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      m_in        = m_ff;
      j_in        = j_ff;
      sel_in      = sel_ff;
      cur_off_in  = cur_off_ff;
      cur_sz_in   = cur_sz_ff;
      a_in        = a_ff;
      acc_in      = acc_ff;
      total_in    = total_ff;
      pend_off_in = pend_off_ff;
      pend_sz_in  = pend_sz_ff;
      pend_v_in   = pend_v_ff;
      placed_in   = placed_ff;
      valid_in    = valid_ff;
      bcnt_in     = bcnt_ff;
      nid_in      = nid_ff;
      gid_in      = gid_ff;
      goff_in     = goff_ff;
      st_in       = st_ff;

      if (cmd.cfg_take) begin
         cap_in = csr_data;
      end
      if (cmd.init) begin
         fcnt_in  = (capc != '0) ? CW'(1) : CW'(0);
         total_in = capc;
         valid_in = '0;
         bcnt_in  = '0;
      end
      if (cmd.load) begin
         req_in  = req_data;
         j_in    = '0;
         i_in    = '0;
         gid_in  = 32'd0;
         goff_in = 32'd0;
      end
      if (cmd.j_inc) begin
         j_in = j_ff + JW'(1);
      end
      if (cmd.slot_take || cmd.hit_take) begin
         sel_in = j_ff;
      end
      if (cmd.hit_take) begin
         cur_off_in = ext_off;
         cur_sz_in  = OW'(ext_sz);
      end
      if (cmd.div_go) begin
         cur_off_in = old_off;
         cur_sz_in  = old_sz;
      end
      if (cmd.align_latch) begin
         a_in = a_calc;
      end
      if (cmd.i_inc) begin
         i_in = i_ff + CW'(1);
      end
      if (cmd.rb_start) begin
         k_in      = '0;
         m_in      = '0;
         acc_in    = '0;
         pend_v_in = 1'b0;
         placed_in = 1'b0;
      end
      if ((cmd.rb_first && !need_second) || cmd.rb_second) begin
         k_in = k_ff + CW'(1);
      end
      if (cmd.rb_first && is_ret && ins_before) begin
         placed_in = 1'b1;
      end
      if (do_proc) begin
         if (mg) begin
            pend_sz_in = OW'(emax_x - XW'(pend_off_ff));
         end else begin
            pend_off_in = e_off;
            pend_sz_in  = e_sz;
            pend_v_in   = 1'b1;
         end
      end
      if (wr_en && !cmd.init) begin
         m_in   = m_ff + CW'(1);
         acc_in = acc_ff + wr_d[OW-1:0];
      end
      if (cmd.commit) begin
         bank_in  = !bank_ff;
         fcnt_in  = m_ff;
         total_in = acc_ff;
         if (is_ret) begin
            valid_in[sel_ff] = 1'b0;
            bcnt_in          = bcnt_ff - BW'(1);
         end else begin
            valid_in[sel_ff] = 1'b1;
            bcnt_in          = bcnt_ff + BW'(1);
            gid_in           = nid_ff;
            goff_in          = a64[31:0];
            nid_in           = (nid_ff == 32'hFFFF_FFFF) ? 32'd1 : nid_ff + 32'd1;
         end
      end
      if (cmd.set_st) begin
         st_in = cmd.st_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= afra_pkg::CAP_RESET;
         bank_ff <= 1'b0;
         fcnt_ff <= '0;
         valid_ff <= '0;
         bcnt_ff <= '0;
         nid_ff  <= 32'd1;
         st_ff   <= afra_pkg::ST_OK;
      end else begin
         cap_ff  <= cap_in;
         bank_ff <= bank_in;
         fcnt_ff <= fcnt_in;
         valid_ff <= valid_in;
         bcnt_ff <= bcnt_in;
         nid_ff  <= nid_in;
         st_ff   <= st_in;
      end
      req_ff      <= req_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      m_ff        <= m_in;
      j_ff        <= j_in;
      sel_ff      <= sel_in;
      cur_off_ff  <= cur_off_in;
      cur_sz_ff   <= cur_sz_in;
      a_ff        <= a_in;
      acc_ff      <= acc_in;
      total_ff    <= total_in;
      pend_off_ff <= pend_off_in;
      pend_sz_ff  <= pend_sz_in;
      pend_v_ff   <= pend_v_in;
      placed_ff   <= placed_in;
      gid_ff      <= gid_in;
      goff_ff     <= goff_in;
   end

   // Free list: the current bank is read, the rebuilt list goes to the other bank.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (cmd.init) begin
            free_mem[bank_ff][0] <= wr_d;
         end else begin
            free_mem[!bank_ff][m_ff[IW-1:0]] <= wr_d;
         end
      end
      if (rd_en) begin
         rd_q <= free_mem[bank_ff][rd_idx];
      end
   end

   // Borrow table: id, granted offset and size per slot.
   always_ff @(posedge clock) begin
      if (cmd.commit && !is_ret) begin
         ext_mem[sel_ff] <= {nid_ff, a_ff, req_ff.request_size};
      end
      if (cmd.tag_rd) begin
         ext_q <= ext_mem[j_ff];
      end
   end

   always_comb begin
      sts.is_ret      = is_ret;
      sts.size0       = (req_ff.request_size == 32'd0);
      sts.align0      = (req_ff.request_alignment == 32'd0);
      sts.id0         = (req_ff.return_id == 32'd0);
      sts.tag_free    = !valid_ff[j_ff];
      sts.tag_match   = valid_ff[j_ff] && (ext_id == req_ff.return_id) &&
                        (64'(ext_off) == 64'(req_ff.return_offset)) &&
                        (ext_sz == req_ff.return_size);
      sts.j_last      = (j_ff == JW'(MB - 1));
      sts.i_lt        = (i_ff < fcnt_ff);
      sts.div_done    = div_done;
      sts.fits        = fits;
      sts.k_lt        = (k_ff < fcnt_ff);
      sts.need_second = need_second;
   end

   assign tot64  = 64'(total_ff);
   assign bcnt64 = 64'(bcnt_ff);

   always_comb begin
      rsp_data.status         = st_ff;
      rsp_data.granted_id     = gid_ff;
      rsp_data.granted_offset = goff_ff;
      rsp_data.free_total     = tot64[31:0];
      rsp_data.borrow_count   = bcnt64[4:0];
   end

endmodule

`default_nettype wire

[rtl/core/aligned_first_fit_range_allocator_core.sv]
`default_nettype none

// Aligned first-fit range allocator. A word is issued by raising start while busy is low;
// busy then stays high until the single result word has been shown on rsp_data for one
// cycle with rsp_valid high. The receiver cannot stall, so it must take the result in
// that cycle. A borrow scans the borrow-table slots in turn to find a free slot, then
// for each free range it tries it runs the one-bit-per-cycle remainder unit that aligns
// the range start; a success then rebuilds the free list range by range, with one more
// step for a split-off tail, then the tail, flush, commit and finish states. A return
// reads and checks the table slot by slot until it matches, then rebuilds the list the
// same way, with the extra step going to the inserted range. Writing the capacity over
// the csr port (only while idle) reloads the free list to one range covering the
// capacity, or to none if it is zero, and drops every borrow; this and reset each pass
// through the initialization state.
module aligned_first_fit_range_allocator_core #(
   parameter int MAX_BORROWS  = afra_pkg::DEF_MAX_BORROWS,
   parameter int OFFSET_WIDTH = afra_pkg::DEF_OFFSET_WIDTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire afra_pkg::req_type req_data,
   output logic                   rsp_valid,
   output afra_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_data
);

   afra_pkg::cmd_type cmd;
   afra_pkg::sts_type sts;

   // The controller sequences every step; the datapath holds all storage.
   afra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .sts       (sts),
      .busy      (busy),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   afra_dp #(
      .MAX_BORROWS  (MAX_BORROWS),
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_data (csr_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   // A result strobe lasts a single cycle and returns the block to idle.
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe held longer than one cycle");

   // Any failed operation reports neither an id nor an offset.
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != afra_pkg::ST_OK) |->
      (rsp_data.granted_id == 32'd0 && rsp_data.granted_offset == 32'd0))
      else $error("error result carries a grant");

   // An issued word makes the block busy on the next cycle.
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // A capacity write is never taken together with a new word.
   a_cfg_excl : assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !start && !busy)
      else $error("capacity write overlapped an operation");

endmodule

`default_nettype wire
